// ===== rtl/core/text_console_writer_defines.svh =====
// Assertion macros used by the console sequencer
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef ASSERT_OFF
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TCW_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TCW_ASSERT(label, prop, msg)
`define TCW_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== rtl/core/tcw_pkg.sv =====
// Package: console geometry, codes, shared types and helpers
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;

  localparam logic [COL_W-1:0]  COL_LIMIT  = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] CELL_COUNT = ADDR_W'(CELLS);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'd7;

  typedef enum logic [1:0] {
    K_PUT   = 2'd0,
    K_SET   = 2'd1,
    K_CLEAR = 2'd2,
    K_READ  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY,
    ST_BLANK,
    ST_PUT,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              load;
    logic              step;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] stop;
  } sweep_cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [7:0]       rchar;
    logic [7:0]       rattr;
  } res_t;

  function automatic logic [ADDR_W-1:0] cell_pos(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
    return ADDR_W'(row) * ROW_STRIDE + ADDR_W'(col);
  endfunction

endpackage

// ===== rtl/core/tcw_cell_mem.sv =====
// Character cell store: one write port, one registered read port
`timescale 1ns / 1ps
module tcw_cell_mem
  import tcw_pkg::*;
(
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == rd_addr)) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/tcw_sweep.sv =====
// Address sweep counter shared by init, clear and scroll passes
`timescale 1ns / 1ps
module tcw_sweep
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  sweep_cmd_t        cmd,
  output logic [ADDR_W-1:0] addr,
  output logic              last
);

  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] stop_r, stop_nxt;

  always_comb begin
    addr_nxt = addr_r;
    stop_nxt = stop_r;
    if (cmd.load) begin
      addr_nxt = cmd.start;
      stop_nxt = cmd.stop;
    end else if (cmd.step) begin
      addr_nxt = addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      stop_r <= LAST_CELL;
    end else begin
      addr_r <= addr_nxt;
      stop_r <= stop_nxt;
    end
  end

  assign addr = addr_r;
  assign last = (addr_r == stop_r);

endmodule

// ===== rtl/core/tcw_ctrl.sv =====
// Sequencer: cursor, attribute register and cell store operations
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_char_code,
  input  logic [COL_W-1:0]  in_new_column,
  input  logic [ROW_W-1:0]  in_new_row,
  input  logic [ADDR_W-1:0] in_cell_index,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [7:0]        attr_r;
  logic [7:0]        char_r, char_nxt;
  logic              pend_r, pend_nxt;
  logic              oor_r, oor_nxt;
  logic [CELL_W-1:0] read_r, read_nxt;
  mem_wr_t           wq_r, wq_nxt;
  logic              wq_from_ram_r, wq_from_ram_nxt;

  sweep_cmd_t        sw_cmd;
  logic [ADDR_W-1:0] sw_addr;
  logic              sw_last;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;
  mem_wr_t           mem_wr;

  tcw_sweep u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (sw_cmd),
    .addr  (sw_addr),
    .last  (sw_last)
  );

  tcw_cell_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    mem_wr      = wq_r;
    mem_wr.data = wq_from_ram_r ? rd_data : wq_r.data;
  end

  always_comb begin
    state_nxt       = state_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    char_nxt        = char_r;
    pend_nxt        = pend_r;
    oor_nxt         = oor_r;
    read_nxt        = read_r;
    wq_nxt.en       = 1'b0;
    wq_nxt.addr     = sw_addr;
    wq_nxt.data     = {attr_r, CH_SPACE};
    wq_from_ram_nxt = 1'b0;
    sw_cmd.load     = 1'b0;
    sw_cmd.step     = 1'b0;
    sw_cmd.start    = '0;
    sw_cmd.stop     = LAST_CELL;
    rd_addr         = '0;
    in_stall        = (state_r != ST_IDLE);
    res_valid       = 1'b0;

    unique case (state_r)
      ST_INIT: begin
        wq_nxt.en   = 1'b1;
        wq_nxt.data = {RESET_ATTR, CH_SPACE};
        sw_cmd.step = 1'b1;
        if (sw_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          read_nxt = '0;
          pend_nxt = 1'b0;
          unique case (kind_t'(in_kind))
            K_PUT: begin
              char_nxt = in_char_code;
              if (in_char_code == CH_NEWLINE) begin
                col_nxt   = '0;
                state_nxt = ST_DONE;
                if (row_r == LAST_ROW) begin
                  sw_cmd.load = 1'b1;
                  sw_cmd.stop = LAST_COPY;
                  state_nxt   = ST_COPY;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end else if (in_char_code == CH_RETURN) begin
                col_nxt   = '0;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_PUT;
                if (col_r >= COL_LIMIT) begin
                  col_nxt = '0;
                  if (row_r == LAST_ROW) begin
                    sw_cmd.load = 1'b1;
                    sw_cmd.stop = LAST_COPY;
                    pend_nxt    = 1'b1;
                    state_nxt   = ST_COPY;
                  end else begin
                    row_nxt = row_r + 1'b1;
                  end
                end
              end
            end
            K_SET: begin
              col_nxt   = (in_new_column > COL_LIMIT) ? COL_LIMIT : in_new_column;
              row_nxt   = (in_new_row > LAST_ROW) ? LAST_ROW : in_new_row;
              state_nxt = ST_DONE;
            end
            K_CLEAR: begin
              sw_cmd.load = 1'b1;
              state_nxt   = ST_BLANK;
            end
            K_READ: begin
              oor_nxt   = (in_cell_index >= CELL_COUNT);
              rd_addr   = (in_cell_index >= CELL_COUNT) ? '0 : in_cell_index;
              state_nxt = ST_READ;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_COPY: begin
        rd_addr         = sw_addr + ROW_STRIDE;
        wq_nxt.en       = 1'b1;
        wq_from_ram_nxt = 1'b1;
        sw_cmd.step     = 1'b1;
        if (sw_last) begin
          sw_cmd.load  = 1'b1;
          sw_cmd.start = BOTTOM_ROW;
          state_nxt    = ST_BLANK;
        end
      end
      ST_BLANK: begin
        wq_nxt.en   = 1'b1;
        sw_cmd.step = 1'b1;
        if (sw_last) begin
          state_nxt = pend_r ? ST_PUT : ST_DONE;
        end
      end
      ST_PUT: begin
        wq_nxt.en   = 1'b1;
        wq_nxt.addr = cell_pos(col_r, row_r);
        wq_nxt.data = {attr_r, char_r};
        col_nxt     = col_r + 1'b1;
        pend_nxt    = 1'b0;
        state_nxt   = ST_DONE;
      end
      ST_READ: begin
        read_nxt  = oor_r ? '0 : rd_data;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      col_r   <= '0;
      row_r   <= '0;
      attr_r  <= RESET_ATTR;
      pend_r  <= 1'b0;
      wq_r    <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pend_r  <= pend_nxt;
      wq_r    <= wq_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    char_r        <= char_nxt;
    oor_r         <= oor_nxt;
    read_r        <= read_nxt;
    wq_from_ram_r <= wq_from_ram_nxt;
  end

  assign res.col   = col_r;
  assign res.row   = row_r;
  assign res.rchar = read_r[7:0];
  assign res.rattr = read_r[15:8];

  `TCW_ASSERT(a_cursor_range, (col_r <= COL_LIMIT) && (row_r <= LAST_ROW), "cursor out of range")
  `TCW_ASSERT(a_write_in_range, !wq_r.en || (wq_r.addr < CELL_COUNT), "cell write out of range")
  `TCW_ASSERT_NEXT(a_hold_result, (state_r == ST_DONE) && !res_ready,
                   (state_r == ST_DONE) && $stable(col_r) && $stable(row_r) && $stable(read_r),
                   "result changed while held")
  `TCW_ASSERT_NEXT(a_oor_reads_zero, (state_r == ST_READ) && oor_r, read_r == '0,
                   "out of range read returned data")
  `TCW_ASSERT_NEXT(a_put_advances, state_r == ST_PUT, col_r == $past(col_r) + 1'b1,
                   "put did not advance cursor")

endmodule

// ===== rtl/core/text_console_writer.sv =====
// Top level: text console writer with registered result beat
//
// Text-mode console of 80 x 25 character cells plus a cursor. Each input beat
// (in_valid / in_stall) carries one command: put character, set cursor, clear
// screen or read cell. Every command yields exactly one result beat
// (out_valid / out_stall) with the cursor column, row and linear position,
// and for a read the cell's character and attribute.
// cfg_wr_en / cfg_wr_data write the attribute used for new characters and
// blanks; write it only while the block is idle.
// Set cursor, carriage return and newline without scroll go straight to the
// result state; a printable put first passes a write state and a read a read
// state. A clear blanks every cell; a scroll (newline or wrap on the bottom
// row) copies each row up one and blanks the bottom row, then writes the
// character if one follows. All cell moves go through a single address sweep
// counter and the one-read, one-write cell store, one cell per cycle. in_stall
// stays high until the result is registered, so one command is in flight at a
// time. After reset the store is filled with blanks (attribute 7) in one pass,
// with in_stall high; configuration writes are taken during it.
// While out_stall is high the result is held and the next command may be
// accepted; its result waits until the output register frees up.
`timescale 1ns / 1ps
module text_console_writer
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_char_code,
  input  logic [COL_W-1:0]  in_new_column,
  input  logic [ROW_W-1:0]  in_new_row,
  input  logic [ADDR_W-1:0] in_cell_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COL_W-1:0]  out_cursor_column,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic [ADDR_W-1:0] out_cursor_position,
  output logic [7:0]        out_read_char,
  output logic [7:0]        out_read_attr
);

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;
  logic [ADDR_W-1:0] out_pos_r;

  tcw_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_char_code  (in_char_code),
    .in_new_column (in_new_column),
    .in_new_row    (in_new_row),
    .in_cell_index (in_cell_index),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
      out_pos_r <= cell_pos(res.col, res.row);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_column   = out_res_r.col;
  assign out_cursor_row      = out_res_r.row;
  assign out_cursor_position = out_pos_r;
  assign out_read_char       = out_res_r.rchar;
  assign out_read_attr       = out_res_r.rattr;

endmodule
